// ----- rtl/brm_pkg.sv -----
// Shared opcodes, flag positions and execute result type for the byte register machine.
`timescale 1ns / 1ps

package brm_pkg;

  // Opcode byte encodings
  typedef enum logic [7:0] {
    OP_INC  = 8'h01,
    OP_DEC  = 8'h02,
    OP_MOV  = 8'h03,
    OP_MOVC = 8'h04,
    OP_LSL  = 8'h05,
    OP_LSR  = 8'h06,
    OP_JMP  = 8'h07,
    OP_JZ   = 8'h08,
    OP_JNZ  = 8'h09,
    OP_JFE  = 8'h0A,
    OP_HALT = 8'h0B,
    OP_ADD  = 8'h0C,
    OP_SUB  = 8'h0D,
    OP_XOR  = 8'h0E,
    OP_OR   = 8'h0F,
    OP_IN   = 8'h10,
    OP_OUT  = 8'h11,
    OP_JO   = 8'h12
  } brm_op_e;

  // Flag bit positions
  localparam int unsigned FlagZero = 0;
  localparam int unsigned FlagOvf  = 1;
  localparam int unsigned FlagEoi  = 2;

  localparam int unsigned FlagW  = 3;
  localparam int unsigned RegIdxW = 4;

  // Outcome of one executed instruction
  typedef struct packed {
    logic [7:0]         next_pc;
    logic               we;
    logic [RegIdxW-1:0] widx;
    logic [7:0]         wdata;
    logic               out_valid;
    logic [7:0]         out_byte;
    logic               taken;
    logic               halted;
    logic               illegal;
    logic               set_eoi;
  } brm_exec_t;

endpackage

// ----- rtl/brm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module brm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/brm_alu.sv -----
// Combinational instruction execute: ALU, branch resolution and halt handling.
`timescale 1ns / 1ps

module brm_alu (
  input  logic [7:0]               op_i,
  input  logic [7:0]               operand_i,
  input  logic [7:0]               symbol_i,
  input  logic                     avail_i,
  input  logic [7:0]               rx_val_i,
  input  logic [7:0]               ry_val_i,
  input  logic [7:0]               pc_i,
  input  logic [brm_pkg::FlagW-1:0] flags_i,
  input  logic                     halt_i,
  output brm_pkg::brm_exec_t       ex_o
);

  logic [7:0] pc_seq;
  logic [7:0] pc_jmp;

  assign pc_seq = pc_i + 8'd2;
  // Offset is a signed byte; modulo-256 add gives the same result
  assign pc_jmp = pc_i + operand_i;

  always_comb begin
    ex_o           = '0;
    ex_o.next_pc   = pc_seq;
    ex_o.widx      = operand_i[brm_pkg::RegIdxW-1:0];
    ex_o.halted    = halt_i;
    if (halt_i) begin
      // Machine stopped: pc frozen, nothing else happens
      ex_o.next_pc = pc_i;
    end else begin
      unique case (op_i)
        brm_pkg::OP_INC: begin
          ex_o.we    = 1'b1;
          ex_o.wdata = rx_val_i + 8'd1;
        end
        brm_pkg::OP_DEC: begin
          ex_o.we    = 1'b1;
          ex_o.wdata = rx_val_i - 8'd1;
        end
        brm_pkg::OP_MOV: begin
          ex_o.we    = 1'b1;
          ex_o.wdata = ry_val_i;
        end
        brm_pkg::OP_MOVC: begin
          ex_o.we    = 1'b1;
          ex_o.widx  = '0;
          ex_o.wdata = operand_i;
        end
        brm_pkg::OP_LSL: begin
          ex_o.we    = 1'b1;
          ex_o.wdata = {rx_val_i[6:0], 1'b0};
        end
        brm_pkg::OP_LSR: begin
          ex_o.we    = 1'b1;
          ex_o.wdata = {1'b0, rx_val_i[7:1]};
        end
        brm_pkg::OP_JMP: ex_o.next_pc = pc_jmp;
        brm_pkg::OP_JZ: begin
          if (flags_i[brm_pkg::FlagZero]) ex_o.next_pc = pc_jmp;
        end
        brm_pkg::OP_JNZ: begin
          if (!flags_i[brm_pkg::FlagZero]) ex_o.next_pc = pc_jmp;
        end
        brm_pkg::OP_JFE: begin
          if (flags_i[brm_pkg::FlagEoi]) ex_o.next_pc = pc_jmp;
        end
        brm_pkg::OP_HALT: begin
          ex_o.halted  = 1'b1;
          ex_o.next_pc = pc_i;
        end
        brm_pkg::OP_ADD: begin
          ex_o.we    = 1'b1;
          ex_o.wdata = rx_val_i + ry_val_i;
        end
        brm_pkg::OP_SUB: begin
          ex_o.we    = 1'b1;
          ex_o.wdata = rx_val_i - ry_val_i;
        end
        brm_pkg::OP_XOR: begin
          ex_o.we    = 1'b1;
          ex_o.wdata = rx_val_i ^ ry_val_i;
        end
        brm_pkg::OP_OR: begin
          ex_o.we    = 1'b1;
          ex_o.wdata = rx_val_i | ry_val_i;
        end
        brm_pkg::OP_IN: begin
          if (avail_i) begin
            ex_o.we    = 1'b1;
            ex_o.wdata = symbol_i;
            ex_o.taken = 1'b1;
          end else begin
            ex_o.set_eoi = 1'b1;
          end
        end
        brm_pkg::OP_OUT: begin
          ex_o.out_valid = 1'b1;
          ex_o.out_byte  = rx_val_i;
        end
        brm_pkg::OP_JO: begin
          if (flags_i[brm_pkg::FlagOvf]) ex_o.next_pc = pc_jmp;
        end
        default: ex_o.illegal = 1'b1;
      endcase
    end
  end

endmodule

// ----- rtl/byte_register_machine_execute.sv -----
// Top level of the byte register machine execute unit.
//
// Request channel (req_valid_i / req_stall_o) carries one two-byte instruction
// word plus the current input symbol and its availability. Response channel
// (rsp_valid_o / rsp_stall_i) returns one word per instruction: next pc, OUT
// byte, IN consumption, halt mark and illegal-opcode flag.
// A word is moved on a rising edge with valid high and stall low.
// Pipeline: request register (register file read, with bypass of the write
// made at the same edge), then execute and writeback into the response
// register. Throughput is one instruction per cycle while the response side
// does not stall; the limit is the single register file write port and pc
// update, done once per cycle in the execute step.
// Reset clears pc, flags, halt mark, register valid bits (registers read as
// zero until written) and both pipeline valids; no clearing pass is needed.
// A response stall holds the response register; the request register then
// fills and req_stall_o rises, while an empty request stage keeps accepting.
`timescale 1ns / 1ps

module byte_register_machine_execute #(
  parameter int unsigned NUM_REGS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       req_valid_i,
  output logic       req_stall_o,
  input  logic [7:0] req_type_i,
  input  logic [7:0] instr_operand_i,
  input  logic [7:0] in_symbol_i,
  input  logic       in_available_i,
  // response channel
  output logic       rsp_valid_o,
  input  logic       rsp_stall_i,
  output logic [7:0] next_pc_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       symbol_taken_o,
  output logic       halted_o,
  output logic       illegal_op_o
);

  localparam int unsigned AW = $clog2(NUM_REGS);
  localparam int unsigned IW = brm_pkg::RegIdxW;
  localparam logic [IW:0] NumRegsW = (IW + 1)'(NUM_REGS);

  // Handshake events
  logic req_fire;
  logic exec_fire;

  // Request stage
  logic       s1_vld_q, s1_vld_d;
  logic [7:0] s1_op_q;
  logic [7:0] s1_opd_q;
  logic [7:0] s1_sym_q;
  logic       s1_avail_q;
  logic       x_vld_q, y_vld_q;
  logic       x_hit_q, y_hit_q;
  logic [7:0] fwd_q;

  // Architectural state
  logic [7:0]                pc_q;
  logic [brm_pkg::FlagW-1:0] flags_q;
  logic                      halt_q;
  logic [NUM_REGS-1:0]       rf_vld_q;

  // Response register
  logic       rsp_vld_q, rsp_vld_d;
  logic [7:0] rsp_pc_q;
  logic       rsp_out_vld_q;
  logic [7:0] rsp_out_byte_q;
  logic       rsp_taken_q;
  logic       rsp_halted_q;
  logic       rsp_illegal_q;

  // Read / write indexes
  logic [IW-1:0] rx_idx, ry_idx;
  logic          rx_in, ry_in;
  logic          wr_en;
  logic [7:0]    ram_x_rdata, ram_y_rdata;
  logic [7:0]    rx_val, ry_val;

  brm_pkg::brm_exec_t ex;

  assign exec_fire   = s1_vld_q && (!rsp_vld_q || !rsp_stall_i);
  assign req_stall_o = s1_vld_q && !exec_fire;
  assign req_fire    = req_valid_i && !req_stall_o;

  assign rx_idx = instr_operand_i[IW-1:0];
  assign ry_idx = instr_operand_i[2*IW-1:IW];
  assign rx_in  = {1'b0, rx_idx} < NumRegsW;
  assign ry_in  = {1'b0, ry_idx} < NumRegsW;
  assign wr_en  = exec_fire && ex.we && ({1'b0, ex.widx} < NumRegsW);

  // Register file: two copies give two read ports
  brm_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_ram_x (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ex.widx[AW-1:0]),
    .wdata_i (ex.wdata),
    .re_i    (req_fire),
    .raddr_i (rx_idx[AW-1:0]),
    .rdata_o (ram_x_rdata)
  );

  brm_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_ram_y (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ex.widx[AW-1:0]),
    .wdata_i (ex.wdata),
    .re_i    (req_fire),
    .raddr_i (ry_idx[AW-1:0]),
    .rdata_o (ram_y_rdata)
  );

  // Request stage valid
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (req_fire) begin
      s1_vld_d = 1'b1;
    end else if (exec_fire) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  // Request payload, entry valid and bypass of the same-edge write
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_op_q    <= req_type_i;
      s1_opd_q   <= instr_operand_i;
      s1_sym_q   <= in_symbol_i;
      s1_avail_q <= in_available_i;
      x_vld_q    <= rx_in && rf_vld_q[rx_idx[AW-1:0]];
      y_vld_q    <= ry_in && rf_vld_q[ry_idx[AW-1:0]];
      x_hit_q    <= wr_en && (ex.widx == rx_idx);
      y_hit_q    <= wr_en && (ex.widx == ry_idx);
      fwd_q      <= ex.wdata;
    end
  end

  // Operand values; never-written entries read as zero
  assign rx_val = x_hit_q ? fwd_q : (x_vld_q ? ram_x_rdata : 8'h00);
  assign ry_val = y_hit_q ? fwd_q : (y_vld_q ? ram_y_rdata : 8'h00);

  brm_alu u_alu (
    .op_i      (s1_op_q),
    .operand_i (s1_opd_q),
    .symbol_i  (s1_sym_q),
    .avail_i   (s1_avail_q),
    .rx_val_i  (rx_val),
    .ry_val_i  (ry_val),
    .pc_i      (pc_q),
    .flags_i   (flags_q),
    .halt_i    (halt_q),
    .ex_o      (ex)
  );

  // Architectural state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      flags_q  <= '0;
      halt_q   <= 1'b0;
      rf_vld_q <= '0;
    end else if (exec_fire) begin
      pc_q   <= ex.next_pc;
      halt_q <= ex.halted;
      if (ex.set_eoi) begin
        flags_q[brm_pkg::FlagEoi] <= 1'b1;
      end
      if (wr_en) begin
        rf_vld_q[ex.widx[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Response register
  always_comb begin
    rsp_vld_d = rsp_vld_q;
    if (exec_fire) begin
      rsp_vld_d = 1'b1;
    end else if (!rsp_stall_i) begin
      rsp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      rsp_pc_q       <= ex.next_pc;
      rsp_out_vld_q  <= ex.out_valid;
      rsp_out_byte_q <= ex.out_byte;
      rsp_taken_q    <= ex.taken;
      rsp_halted_q   <= ex.halted;
      rsp_illegal_q  <= ex.illegal;
    end
  end

  assign rsp_valid_o    = rsp_vld_q;
  assign next_pc_o      = rsp_pc_q;
  assign out_valid_o    = rsp_out_vld_q;
  assign out_byte_o     = rsp_out_byte_q;
  assign symbol_taken_o = rsp_taken_q;
  assign halted_o       = rsp_halted_q;
  assign illegal_op_o   = rsp_illegal_q;

`ifndef SYNTHESIS
  // Halt mark is sticky until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt mark cleared");

  // A halted machine never writes the register file
  a_no_write_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> !wr_en)
    else $error("register write after halt");

  // pc follows the executed instruction
  a_pc_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> pc_q == $past(ex.next_pc))
    else $error("pc not updated from execute");

  // Illegal opcode only advances the pc
  a_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && ex.illegal) |-> (!ex.we && !ex.out_valid && !ex.set_eoi
      && ex.next_pc == pc_q + 8'd2))
    else $error("illegal opcode changed state");

  // Request stall only when the request stage is occupied
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_stall_o |-> (s1_vld_q && rsp_vld_q && rsp_stall_i))
    else $error("request stalled without a blocked response");
`endif

endmodule

// ----- verif/byte_register_machine_execute_tb.sv -----
// Testbench for the byte register machine execute unit: directed table, random run, halt.
`timescale 1ns / 1ps

module byte_register_machine_execute_tb;

  localparam int unsigned RandomWords = 1280;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned DrainCycles = 10;

  // opcode bytes that decode to nothing
  localparam logic [7:0] OpNone     = 8'h00;
  localparam logic [7:0] OpPastLast = 8'h13;
  localparam logic [7:0] OpTop      = 8'hFF;

  // one response word, in port order
  typedef struct packed {
    logic [7:0] next_pc;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       symbol_taken;
    logic       halted;
    logic       illegal_op;
  } exec_result_t;

  // one instruction word plus an optional hand-written expectation
  typedef struct {
    logic [7:0]   op;
    logic [7:0]   operand;
    logic [7:0]   symbol;
    logic         avail;
    bit           typed;
    exec_result_t want;
  } instr_row_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       req_valid_i     = 1'b0;
  logic       req_stall_o;
  logic [7:0] req_type_i      = 8'h00;
  logic [7:0] instr_operand_i = 8'h00;
  logic [7:0] in_symbol_i     = 8'h00;
  logic       in_available_i  = 1'b0;
  logic       rsp_valid_o;
  logic       rsp_stall_i     = 1'b0;
  logic [7:0] next_pc_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       symbol_taken_o;
  logic       halted_o;
  logic       illegal_op_o;

  byte_register_machine_execute #(
    .NUM_REGS(16)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_i),
    .req_stall_o    (req_stall_o),
    .req_type_i     (req_type_i),
    .instr_operand_i(instr_operand_i),
    .in_symbol_i    (in_symbol_i),
    .in_available_i (in_available_i),
    .rsp_valid_o    (rsp_valid_o),
    .rsp_stall_i    (rsp_stall_i),
    .next_pc_o      (next_pc_o),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .symbol_taken_o (symbol_taken_o),
    .halted_o       (halted_o),
    .illegal_op_o   (illegal_op_o)
  );

  always #5 clk_i = ~clk_i;

  // machine state as the predictor sees it
  logic [7:0]                mach_regs [16];
  logic [7:0]                mach_pc     = 8'h00;
  logic [brm_pkg::FlagW-1:0] mach_flags  = '0;
  logic                      mach_halted = 1'b0;

  exec_result_t expected_words[$];
  instr_row_t   directed_rows[$];
  int unsigned  halt_row_start;

  int unsigned cycle_count    = 0;
  int unsigned words_sent     = 0;
  int unsigned words_checked  = 0;
  int unsigned mismatch_count = 0;
  int unsigned failure_count  = 0;
  int unsigned illegal_count  = 0;
  int unsigned jump_count     = 0;
  int unsigned eoi_count      = 0;
  int unsigned out_count      = 0;
  int unsigned sender_burst   = 0;
  int unsigned sink_burst     = 0;
  int unsigned sink_hold      = 0;

  initial begin
    foreach (mach_regs[i]) mach_regs[i] = 8'h00;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_words.size());
      $display("status: fail");
      $finish;
    end
  end

  // wait length for one word, with occasional stretches of no waiting
  function automatic int unsigned draw_wait(inout int unsigned burst_left);
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst_left = $urandom_range(15, 60);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // executes one instruction on the predictor state and returns its response word
  function automatic exec_result_t execute_instr(instr_row_t row);
    exec_result_t r;
    logic [3:0]   rx;
    logic [3:0]   ry;
    logic [7:0]   npc;
    logic [7:0]   target;
    bit           jumped;
    r      = '0;
    rx     = row.operand[3:0];
    ry     = row.operand[7:4];
    npc    = mach_pc + 8'd2;
    target = mach_pc + row.operand;
    jumped = 1'b0;
    if (mach_halted) begin
      npc = mach_pc;
    end else begin
      case (row.op)
        brm_pkg::OP_INC:  mach_regs[rx] = mach_regs[rx] + 8'd1;
        brm_pkg::OP_DEC:  mach_regs[rx] = mach_regs[rx] - 8'd1;
        brm_pkg::OP_MOV:  mach_regs[rx] = mach_regs[ry];
        brm_pkg::OP_MOVC: mach_regs[0] = row.operand;
        brm_pkg::OP_LSL:  mach_regs[rx] = mach_regs[rx] << 1;
        brm_pkg::OP_LSR:  mach_regs[rx] = mach_regs[rx] >> 1;
        brm_pkg::OP_JMP:  jumped = 1'b1;
        brm_pkg::OP_JZ:   jumped = mach_flags[brm_pkg::FlagZero];
        brm_pkg::OP_JNZ:  jumped = !mach_flags[brm_pkg::FlagZero];
        brm_pkg::OP_JFE:  jumped = mach_flags[brm_pkg::FlagEoi];
        brm_pkg::OP_JO:   jumped = mach_flags[brm_pkg::FlagOvf];
        brm_pkg::OP_HALT: begin
          mach_halted = 1'b1;
          npc = mach_pc;
        end
        brm_pkg::OP_ADD:  mach_regs[rx] = mach_regs[rx] + mach_regs[ry];
        brm_pkg::OP_SUB:  mach_regs[rx] = mach_regs[rx] - mach_regs[ry];
        brm_pkg::OP_XOR:  mach_regs[rx] = mach_regs[rx] ^ mach_regs[ry];
        brm_pkg::OP_OR:   mach_regs[rx] = mach_regs[rx] | mach_regs[ry];
        brm_pkg::OP_IN: begin
          if (row.avail) begin
            mach_regs[rx] = row.symbol;
            r.symbol_taken = 1'b1;
          end else begin
            mach_flags[brm_pkg::FlagEoi] = 1'b1;
            eoi_count++;
          end
        end
        brm_pkg::OP_OUT: begin
          r.out_valid = 1'b1;
          r.out_byte  = mach_regs[rx];
          out_count++;
        end
        default: begin
          r.illegal_op = 1'b1;
          illegal_count++;
        end
      endcase
      if (jumped) begin
        npc = target;
        jump_count++;
      end
    end
    mach_pc   = npc;
    r.next_pc = npc;
    r.halted  = mach_halted;
    return r;
  endfunction

  task automatic add_row(input logic [7:0] op, input logic [7:0] operand,
                         input logic [7:0] symbol, input logic avail);
    instr_row_t row;
    row.op      = op;
    row.operand = operand;
    row.symbol  = symbol;
    row.avail   = avail;
    row.typed   = 1'b0;
    row.want    = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [7:0] op, input logic [7:0] operand,
                           input logic [7:0] symbol, input logic avail,
                           input exec_result_t want);
    instr_row_t row;
    row.op      = op;
    row.operand = operand;
    row.symbol  = symbol;
    row.avail   = avail;
    row.typed   = 1'b1;
    row.want    = want;
    directed_rows.push_back(row);
  endtask

  // random instruction: mostly legal work, some loads, a little garbage
  function automatic instr_row_t random_instr();
    instr_row_t  row;
    int unsigned pick;
    pick        = $urandom_range(0, 99);
    row.operand = 8'($urandom_range(0, 255));
    row.symbol  = 8'($urandom_range(0, 255));
    row.avail   = ($urandom_range(0, 11) != 0);
    row.typed   = 1'b0;
    row.want    = '0;
    if (pick < 8) begin
      if ($urandom_range(0, 3) == 0) row.op = OpNone;
      else row.op = 8'($urandom_range(OpTop, OpPastLast));
    end else if (pick < 22) begin
      row.op = ($urandom_range(0, 1) != 0) ? brm_pkg::OP_MOVC : brm_pkg::OP_IN;
    end else begin
      do row.op = 8'($urandom_range(brm_pkg::OP_INC, brm_pkg::OP_JO));
      while (row.op == brm_pkg::OP_HALT);
    end
    return row;
  endfunction

  // send one instruction word, record its expected response at acceptance
  task automatic issue_instr(input instr_row_t row);
    int unsigned  gap;
    exec_result_t predicted;
    gap = draw_wait(sender_burst);
    if (gap != 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i     <= 1'b1;
    req_type_i      <= row.op;
    instr_operand_i <= row.operand;
    in_symbol_i     <= row.symbol;
    in_available_i  <= row.avail;
    do @(posedge clk_i); while (req_stall_o);
    predicted = execute_instr(row);
    expected_words.push_back(row.typed ? row.want : predicted);
    words_sent++;
  endtask

  // hold off the sender until every expected word has come back
  task automatic drain_responses();
    req_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic check_word(input exec_result_t got);
    exec_result_t want;
    bit           bad;
    words_checked++;
    if (expected_words.size() == 0) begin
      failure_count++;
      mismatch_count++;
      if (mismatch_count <= ReportMax)
        $display("unexpected word: pc %02h out %0d/%02h taken %0d halt %0d ill %0d",
                 got.next_pc, got.out_valid, got.out_byte, got.symbol_taken,
                 got.halted, got.illegal_op);
    end else begin
      want = expected_words.pop_front();
      bad  = (got.next_pc !== want.next_pc) || (got.out_valid !== want.out_valid) ||
             (got.out_byte !== want.out_byte) || (got.symbol_taken !== want.symbol_taken) ||
             (got.halted !== want.halted) || (got.illegal_op !== want.illegal_op);
      if (bad) begin
        failure_count++;
        mismatch_count++;
        if (mismatch_count <= ReportMax) begin
          $display("word %0d mismatch: expected pc %02h out %0d/%02h taken %0d halt %0d ill %0d",
                   words_checked, want.next_pc, want.out_valid, want.out_byte,
                   want.symbol_taken, want.halted, want.illegal_op);
          $display("word %0d mismatch:   actual pc %02h out %0d/%02h taken %0d halt %0d ill %0d",
                   words_checked, got.next_pc, got.out_valid, got.out_byte,
                   got.symbol_taken, got.halted, got.illegal_op);
        end
      end
    end
  endtask

  // response side: check accepted words, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o === 1'b1 && !rsp_stall_i) begin
      check_word({next_pc_o, out_valid_o, out_byte_o, symbol_taken_o, halted_o,
                  illegal_op_o});
      sink_hold = draw_wait(sink_burst);
    end
    if (sink_hold != 0) begin
      rsp_stall_i <= 1'b1;
      sink_hold--;
    end else begin
      rsp_stall_i <= 1'b0;
    end
  end

  initial begin : stimulus
    int unsigned i;

    // directed rows; pc starts at 0 and registers at zero after reset
    add_typed(brm_pkg::OP_OUT, 8'h00, 8'h00, 1'b1, {8'h02, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0});
    add_typed(OpNone, 8'hFF, 8'hFF, 1'b1, {8'h04, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1});
    add_typed(OpTop, 8'h00, 8'h00, 1'b0, {8'h06, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1});
    add_typed(OpPastLast, 8'h5A, 8'hA5, 1'b1, {8'h08, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1});
    add_typed(brm_pkg::OP_MOVC, 8'hFF, 8'h00, 1'b1, {8'h0A, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
    add_typed(brm_pkg::OP_OUT, 8'h00, 8'h00, 1'b1, {8'h0C, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0});
    add_row(brm_pkg::OP_INC, 8'h00, 8'h00, 1'b1);   // wraps to zero
    add_row(brm_pkg::OP_DEC, 8'h00, 8'h00, 1'b1);   // wraps back to all ones
    add_row(brm_pkg::OP_MOV, 8'h0F, 8'h00, 1'b1);
    add_row(brm_pkg::OP_IN, 8'h01, 8'h80, 1'b1);
    add_row(brm_pkg::OP_LSL, 8'h01, 8'h00, 1'b1);   // top bit shifted out
    add_row(brm_pkg::OP_IN, 8'h02, 8'hFF, 1'b1);
    add_row(brm_pkg::OP_LSR, 8'h02, 8'h00, 1'b1);
    add_row(brm_pkg::OP_ADD, 8'h2F, 8'h00, 1'b1);
    add_row(brm_pkg::OP_SUB, 8'hF1, 8'h00, 1'b1);   // borrow through zero
    add_row(brm_pkg::OP_XOR, 8'h01, 8'h00, 1'b1);
    add_row(brm_pkg::OP_OR, 8'hF2, 8'h00, 1'b1);
    add_row(brm_pkg::OP_OUT, 8'h0F, 8'h00, 1'b1);
    add_row(brm_pkg::OP_JZ, 8'h10, 8'h00, 1'b1);    // zero flag never set
    add_row(brm_pkg::OP_JNZ, 8'h7F, 8'h00, 1'b1);   // largest forward offset
    add_row(brm_pkg::OP_JFE, 8'h80, 8'h00, 1'b1);   // input not yet exhausted
    add_row(brm_pkg::OP_JO, 8'h04, 8'h00, 1'b1);    // overflow flag never set
    add_row(brm_pkg::OP_IN, 8'h03, 8'hAA, 1'b0);    // end of input, nothing written
    add_row(brm_pkg::OP_JFE, 8'h80, 8'h00, 1'b1);   // largest backward offset
    add_row(brm_pkg::OP_JMP, 8'hFE, 8'h00, 1'b1);
    add_row(brm_pkg::OP_JMP, 8'h00, 8'h00, 1'b1);   // jump to itself
    // closing rows: halt, then words that must leave the state alone
    halt_row_start = directed_rows.size();
    add_row(brm_pkg::OP_HALT, 8'h55, 8'h00, 1'b1);
    add_row(brm_pkg::OP_OUT, 8'h00, 8'h00, 1'b1);
    add_row(brm_pkg::OP_IN, 8'h04, 8'h3C, 1'b1);
    add_row(OpTop, 8'hFF, 8'hFF, 1'b1);
    add_row(brm_pkg::OP_JMP, 8'h10, 8'h00, 1'b1);
    add_row(brm_pkg::OP_HALT, 8'h00, 8'h00, 1'b0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < halt_row_start; i++) issue_instr(directed_rows[i]);
    drain_responses();

    for (i = 0; i < RandomWords; i++) begin
      issue_instr(random_instr());
      if (i == RandomWords / 2) drain_responses();
    end
    drain_responses();

    for (i = halt_row_start; i < directed_rows.size(); i++) issue_instr(directed_rows[i]);
    drain_responses();
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_words.size() != 0) failure_count++;
    $display("sent %0d instruction words, checked %0d response words, %0d mismatches",
             words_sent, words_checked, mismatch_count);
    $display("covered %0d illegal opcodes, %0d taken jumps, %0d OUT, %0d IN at end of input",
             illegal_count, jump_count, out_count, eoi_count);
    if (failure_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- byte_register_machine_execute.f -----
rtl/brm_pkg.sv
rtl/brm_ram.sv
rtl/brm_alu.sv
rtl/byte_register_machine_execute.sv
verif/byte_register_machine_execute_tb.sv
